/* hw/rtl/gpba_pkg.sv */
// ----------------------------------------------------------------------------
// gpba_pkg: shared types and constants for the growing page bump allocator
// Fixed field widths, command and status codes, register indexes and the
// ceiling-log2 helper used by the step logic.
// ----------------------------------------------------------------------------
package gpba_pkg;

	localparam int SIZE_W    = 24;  // req_size
	localparam int ALIGN_W   = 4;   // align_log2
	localparam int ALIGN_MAX = (2 ** ALIGN_W) - 1;
	localparam int CFG_W     = 5;   // min/max page log2 registers
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_W-1:0] MIN_PAGE_LOG2_RST = 5'd12;
	localparam logic [CFG_W-1:0] MAX_PAGE_LOG2_RST = 5'd20;

	typedef enum logic [1:0] {
		ACT_ALLOC   = 2'd0,
		ACT_QUERY   = 2'd1,
		ACT_RESTORE = 2'd2,
		ACT_CLEAR   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_TOO_BIG = 2'd1,
		STAT_FULL    = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_PAGE_LOG2 = 1'b0,
		CFG_MAX_PAGE_LOG2 = 1'b1
	} cfg_idx_t;

	// State update strobes from the step logic to the state registers
	typedef struct packed {
		logic ram_we;    // write the new page size at the stack top
		logic top_load;  // reload the cached top page size
	} step_ctl_t;

	// Smallest k with 2**k >= v; zero and one both give 0
	function automatic logic [CFG_W-1:0] ceil_log2(input logic [SIZE_W-1:0] v);
		logic [SIZE_W-1:0] m;
		logic [CFG_W-1:0]  k;
		m = v - SIZE_W'(1);
		k = '0;
		for (int i = 0; i < SIZE_W; i++) begin
			if (m[i]) begin
				k = CFG_W'(i + 1);
			end
		end
		if (v == '0) begin
			k = '0;
		end
		return k;
	endfunction

endpackage

/* hw/rtl/gpba_ram.sv */
// ----------------------------------------------------------------------------
// gpba_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gpba_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/gpba_step.sv */
// ----------------------------------------------------------------------------
// gpba_step: single-pass allocator step
// Decodes one command against the page count, top page usage and top page
// size, and produces the result word and the next state.
// ----------------------------------------------------------------------------
module gpba_step #(
	parameter int MAX_PAGES     = 16,
	parameter int MAX_PAGE_LOG2 = 20
) (
	input  gpba_pkg::action_t                              action,
	input  logic [gpba_pkg::SIZE_W-1:0]                    req_size,
	input  logic [gpba_pkg::ALIGN_W-1:0]                   align_log2,
	input  logic [$clog2(MAX_PAGES+1)-1:0]                 mark_pages,
	input  logic [MAX_PAGE_LOG2:0]                         mark_usage,
	input  logic [$clog2(MAX_PAGE_LOG2+1)-1:0]             rd_log2,
	input  logic [$clog2(MAX_PAGES+1)-1:0]                 count,
	input  logic [MAX_PAGE_LOG2:0]                         usage,
	input  logic [$clog2(MAX_PAGE_LOG2+1)-1:0]             top_log2,
	input  logic [gpba_pkg::CFG_W-1:0]                     min_cfg,
	input  logic [gpba_pkg::CFG_W-1:0]                     max_cfg,
	output gpba_pkg::status_t                              status,
	output logic [((MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1)-1:0] page_index,
	output logic [$clog2(MAX_PAGE_LOG2+1)-1:0]             page_log2,
	output logic [MAX_PAGE_LOG2:0]                         offset,
	output logic                                           new_page,
	output logic [$clog2(MAX_PAGES+1)-1:0]                 pages_released,
	output logic [$clog2(MAX_PAGES+1)-1:0]                 next_count,
	output logic [MAX_PAGE_LOG2:0]                         next_usage,
	output logic [$clog2(MAX_PAGE_LOG2+1)-1:0]             next_top,
	output gpba_pkg::step_ctl_t                            ctl
);

	localparam int AW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int CNT_W = $clog2(MAX_PAGES + 1);
	localparam int USE_W = MAX_PAGE_LOG2 + 1;
	localparam int LG_W  = $clog2(MAX_PAGE_LOG2 + 1);
	localparam int SUM_W = ((USE_W > gpba_pkg::ALIGN_MAX) ? USE_W : gpba_pkg::ALIGN_MAX) + 1;
	localparam int CW    = ((SUM_W > gpba_pkg::SIZE_W) ? SUM_W : gpba_pkg::SIZE_W) + 1;
	localparam int CFW   = gpba_pkg::CFG_W;

	logic             has_page;
	logic [SUM_W-1:0] amask;
	logic [SUM_W-1:0] aligned;
	logic [CW-1:0]    fit_sum;
	logic [CW-1:0]    psize;
	logic             fits;
	logic [CFW-1:0]   need;
	logic [CFW-1:0]   emax;
	logic [CFW-1:0]   emin;
	logic [CFW:0]     grow;
	logic [CFW-1:0]   base;
	logic [CFW-1:0]   lg;
	logic             too_big;
	logic             full;

	assign has_page = (count != '0);
	assign amask    = ~({SUM_W{1'b1}} << align_log2);
	assign aligned  = (SUM_W'(usage) + amask) & ~amask;
	assign fit_sum  = CW'(aligned) + CW'(req_size);
	assign psize    = CW'(1) << top_log2;
	assign fits     = has_page && (fit_sum <= psize);
	assign need     = gpba_pkg::ceil_log2(req_size);

	// effective limits: max capped by the build limit, min clamped to max
	assign emax = (max_cfg < CFW'(MAX_PAGE_LOG2)) ? max_cfg : CFW'(MAX_PAGE_LOG2);
	assign emin = (min_cfg < emax) ? min_cfg : emax;

	// next page doubles the top page (or takes the minimum when there is none), capped; never below the request
	assign grow = (CFW+1)'(top_log2) + (CFW+1)'(1);
	assign base = has_page ? ((grow > (CFW+1)'(emax)) ? emax : grow[CFW-1:0]) : emin;
	assign lg   = (need > base) ? need : base;

	assign too_big = (need > emax);
	assign full    = (count >= CNT_W'(MAX_PAGES));

	always_comb begin
		status         = gpba_pkg::STAT_OK;
		page_index     = '0;
		page_log2      = '0;
		offset         = '0;
		new_page       = 1'b0;
		pages_released = '0;
		next_count     = count;
		next_usage     = usage;
		next_top       = top_log2;
		ctl            = '0;
		unique case (action)
			gpba_pkg::ACT_ALLOC: begin
				if (fits) begin
					page_index = AW'(count - CNT_W'(1));
					page_log2  = top_log2;
					offset     = USE_W'(aligned);
					next_usage = USE_W'(fit_sum);
				end else if (too_big) begin
					status = gpba_pkg::STAT_TOO_BIG;
				end else if (full) begin
					status = gpba_pkg::STAT_FULL;
				end else begin
					page_index   = AW'(count);
					page_log2    = LG_W'(lg);
					new_page     = 1'b1;
					next_count   = count + CNT_W'(1);
					next_usage   = USE_W'(req_size);
					next_top     = LG_W'(lg);
					ctl.ram_we   = 1'b1;
					ctl.top_load = 1'b1;
				end
			end
			gpba_pkg::ACT_QUERY: begin
			end
			gpba_pkg::ACT_RESTORE: begin
				if (count > mark_pages) begin
					pages_released = count - mark_pages;
					next_count     = mark_pages;
					next_top       = rd_log2;
					ctl.top_load   = 1'b1;
				end
				next_usage = mark_usage;
			end
			gpba_pkg::ACT_CLEAR: begin
				pages_released = count;
				next_count     = '0;
				next_usage     = '0;
			end
		endcase
	end

endmodule

/* hw/rtl/growing_page_bump_allocator_top.sv */
// ----------------------------------------------------------------------------
// growing_page_bump_allocator_top: stack-of-pages bump allocator
// Command register, single-pass step logic, page size stack RAM and a
// result register.
// ----------------------------------------------------------------------------
// Usage:
//   Commands (alloc, query mark, restore mark, clear) enter on the cmd
//   channel, one word per cycle while cmd_ready is high, each giving
//   exactly one result word on the res channel, in order; both use valid/ready.
//   An accepted command waits in the command register; the step logic acts
//   on it as it moves into the result register, which then shows its result.
//   Throughput is one command per cycle while the result is not stalled: the
//   page size stack read for a restore is issued from the command port at
//   acceptance, so the step finds it already registered. The config port
//   writes min_page_log2 or max_page_log2, as cfg_index selects, with
//   cfg_wdata under cfg_we; write only while no command is in flight.
//   Reset: no pages, usage zero, registers back to 12 and 20. The stack RAM
//   is not cleared; only entries below the page count are ever used.
//   When res_ready is low the result word holds, the command register still
//   takes one more word, and cmd_ready then drops until the result drains.
module growing_page_bump_allocator_top #(
	parameter int MAX_PAGES     = 16,
	parameter int MAX_PAGE_LOG2 = 20
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           cmd_valid,
	output logic                                           cmd_ready,
	input  logic [1:0]                                     action,
	input  logic [gpba_pkg::SIZE_W-1:0]                    req_size,
	input  logic [gpba_pkg::ALIGN_W-1:0]                   align_log2,
	input  logic [$clog2(MAX_PAGES+1)-1:0]                 mark_pages,
	input  logic [MAX_PAGE_LOG2:0]                         mark_usage,
	output logic                                           res_valid,
	input  logic                                           res_ready,
	output logic [1:0]                                     status,
	output logic [((MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1)-1:0] page_index,
	output logic [$clog2(MAX_PAGE_LOG2+1)-1:0]             page_log2,
	output logic [MAX_PAGE_LOG2:0]                         offset,
	output logic                                           new_page,
	output logic [$clog2(MAX_PAGES+1)-1:0]                 pages_in_use,
	output logic [MAX_PAGE_LOG2:0]                         used_bytes,
	output logic [$clog2(MAX_PAGES+1)-1:0]                 pages_released,
	input  logic                                           cfg_we,
	input  logic [gpba_pkg::CFG_IDX_W-1:0]                 cfg_index,
	input  logic [gpba_pkg::CFG_W-1:0]                     cfg_wdata
);

	localparam int AW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int CNT_W = $clog2(MAX_PAGES + 1);
	localparam int USE_W = MAX_PAGE_LOG2 + 1;
	localparam int LG_W  = $clog2(MAX_PAGE_LOG2 + 1);

	// command register
	logic                               v_s1;
	gpba_pkg::action_t                  action_s1;
	logic [gpba_pkg::SIZE_W-1:0]        req_size_s1;
	logic [gpba_pkg::ALIGN_W-1:0]       align_log2_s1;
	logic [CNT_W-1:0]                   mark_pages_s1;
	logic [USE_W-1:0]                   mark_usage_s1;
	logic                               fwd_s1;
	logic [LG_W-1:0]                    fwd_data_s1;

	// allocator state
	logic [CNT_W-1:0]                   count_q;
	logic [USE_W-1:0]                   usage_q;
	logic [LG_W-1:0]                    top_q;
	logic [gpba_pkg::CFG_W-1:0]         min_cfg_q;
	logic [gpba_pkg::CFG_W-1:0]         max_cfg_q;

	// result register
	logic                               res_valid_q;
	gpba_pkg::status_t                  status_q;
	logic [AW-1:0]                      page_index_q;
	logic [LG_W-1:0]                    page_log2_q;
	logic [USE_W-1:0]                   offset_q;
	logic                               new_page_q;
	logic [CNT_W-1:0]                   pages_in_use_q;
	logic [USE_W-1:0]                   used_bytes_q;
	logic [CNT_W-1:0]                   pages_released_q;

	logic                               adv;
	logic                               accept;
	logic [AW-1:0]                      rd_addr;
	logic [AW-1:0]                      wr_addr;
	logic                               ram_we;
	logic [LG_W-1:0]                    ram_rdata;
	logic [LG_W-1:0]                    rd_log2;

	gpba_pkg::status_t                  st_status;
	logic [AW-1:0]                      st_page_index;
	logic [LG_W-1:0]                    st_page_log2;
	logic [USE_W-1:0]                   st_offset;
	logic                               st_new_page;
	logic [CNT_W-1:0]                   st_released;
	logic [CNT_W-1:0]                   st_next_count;
	logic [USE_W-1:0]                   st_next_usage;
	logic [LG_W-1:0]                    st_next_top;
	gpba_pkg::step_ctl_t                st_ctl;

	assign adv       = v_s1 && (!res_valid_q || res_ready);
	assign cmd_ready = !v_s1 || adv;
	assign accept    = cmd_valid && cmd_ready;

	// restore needs the entry just below the mark; fetch it at acceptance
	assign rd_addr = AW'(mark_pages - CNT_W'(1));
	assign wr_addr = AW'(count_q);
	assign ram_we  = adv && st_ctl.ram_we;
	assign rd_log2 = fwd_s1 ? fwd_data_s1 : ram_rdata;

	gpba_ram #(
		.WIDTH (LG_W),
		.DEPTH (MAX_PAGES)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_addr),
		.wdata (st_next_top),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	gpba_step #(
		.MAX_PAGES     (MAX_PAGES),
		.MAX_PAGE_LOG2 (MAX_PAGE_LOG2)
	) u_step (
		.action         (action_s1),
		.req_size       (req_size_s1),
		.align_log2     (align_log2_s1),
		.mark_pages     (mark_pages_s1),
		.mark_usage     (mark_usage_s1),
		.rd_log2        (rd_log2),
		.count          (count_q),
		.usage          (usage_q),
		.top_log2       (top_q),
		.min_cfg        (min_cfg_q),
		.max_cfg        (max_cfg_q),
		.status         (st_status),
		.page_index     (st_page_index),
		.page_log2      (st_page_log2),
		.offset         (st_offset),
		.new_page       (st_new_page),
		.pages_released (st_released),
		.next_count     (st_next_count),
		.next_usage     (st_next_usage),
		.next_top       (st_next_top),
		.ctl            (st_ctl)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			fwd_s1      <= 1'b0;
			res_valid_q <= 1'b0;
			count_q     <= '0;
			usage_q     <= '0;
			min_cfg_q   <= gpba_pkg::MIN_PAGE_LOG2_RST;
			max_cfg_q   <= gpba_pkg::MAX_PAGE_LOG2_RST;
		end else begin
			if (accept) begin
				v_s1   <= 1'b1;
				// same-edge push to the entry being fetched: take the new value
				fwd_s1 <= ram_we && (wr_addr == rd_addr);
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				res_valid_q <= 1'b1;
				count_q     <= st_next_count;
				usage_q     <= st_next_usage;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (gpba_pkg::cfg_idx_t'(cfg_index))
					gpba_pkg::CFG_MIN_PAGE_LOG2: min_cfg_q <= cfg_wdata;
					gpba_pkg::CFG_MAX_PAGE_LOG2: max_cfg_q <= cfg_wdata;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1     <= gpba_pkg::action_t'(action);
			req_size_s1   <= req_size;
			align_log2_s1 <= align_log2;
			mark_pages_s1 <= mark_pages;
			mark_usage_s1 <= mark_usage;
			fwd_data_s1   <= st_next_top;
		end
		if (adv && st_ctl.top_load) begin
			top_q <= st_next_top;
		end
		if (adv) begin
			status_q         <= st_status;
			page_index_q     <= st_page_index;
			page_log2_q      <= st_page_log2;
			offset_q         <= st_offset;
			new_page_q       <= st_new_page;
			pages_in_use_q   <= st_next_count;
			used_bytes_q     <= st_next_usage;
			pages_released_q <= st_released;
		end
	end

	assign res_valid      = res_valid_q;
	assign status         = status_q;
	assign page_index     = page_index_q;
	assign page_log2      = page_log2_q;
	assign offset         = offset_q;
	assign new_page       = new_page_q;
	assign pages_in_use   = pages_in_use_q;
	assign used_bytes     = used_bytes_q;
	assign pages_released = pages_released_q;

endmodule

/* hw/rtl/gpba_checker.sv */
// ----------------------------------------------------------------------------
// gpba_checker: port-level checks for the growing page bump allocator
// Watches the result channel and checks that result words are consistent.
// ----------------------------------------------------------------------------
module gpba_checker #(
	parameter int MAX_PAGES     = 16,
	parameter int MAX_PAGE_LOG2 = 20
) (
	input logic                                           clk,
	input logic                                           arst_n,
	input logic                                           res_valid,
	input logic                                           res_ready,
	input logic [1:0]                                     status,
	input logic [((MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1)-1:0] page_index,
	input logic [$clog2(MAX_PAGE_LOG2+1)-1:0]             page_log2,
	input logic [MAX_PAGE_LOG2:0]                         offset,
	input logic                                           new_page,
	input logic [$clog2(MAX_PAGES+1)-1:0]                 pages_in_use,
	input logic [$clog2(MAX_PAGES+1)-1:0]                 pages_released
);

	localparam int CNT_W = $clog2(MAX_PAGES + 1);

	// hold a stalled result word
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(status) && $stable(offset)
			&& $stable(pages_in_use) && $stable(new_page))
		else $error("result word changed while stalled");

	// a failed alloc leaves no placement behind
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status != gpba_pkg::STAT_OK) |-> !new_page && (offset == '0)
			&& (page_log2 == '0) && (pages_released == '0))
		else $error("failed alloc reports a placement");

	// a pushed page sits on top of the stack and starts at offset zero
	a_push_top: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && new_page |-> (offset == '0)
			&& (pages_in_use == CNT_W'(page_index) + CNT_W'(1)))
		else $error("new page is not the stack top");

	// stack full is reported only with every page in use
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == gpba_pkg::STAT_FULL) |-> (pages_in_use == CNT_W'(MAX_PAGES)))
		else $error("stack full reported below capacity");

endmodule

bind growing_page_bump_allocator_top gpba_checker #(
	.MAX_PAGES     (MAX_PAGES),
	.MAX_PAGE_LOG2 (MAX_PAGE_LOG2)
) u_gpba_checker (.*);
